>>> hdl/dfsr_pkg.sv
// Package with the types, codes and constants of the data fault shadow registers.
`timescale 1ns / 1ps

package dfsr_pkg;

  localparam int unsigned RegNumW = 5;
  localparam int unsigned XlenW   = 32;

  localparam logic [RegNumW-1:0] LAST_REG = '1;

  localparam logic CMD_FAULT  = 1'b0;
  localparam logic CMD_SHADOW = 1'b1;

  localparam logic CFG_SHADOW_FROZEN = 1'b0;
  localparam logic CFG_ENDIAN_MODE   = 1'b1;

  localparam logic [1:0] SIZE_BYTE   = 2'd0;
  localparam logic [1:0] SIZE_HALF   = 2'd1;
  localparam logic [1:0] SIZE_WORD   = 2'd2;
  localparam logic [1:0] SIZE_DOUBLE = 2'd3;

  localparam logic [2:0] OP_SIGNED_LOAD   = 3'd0;
  localparam logic [2:0] OP_STORE         = 3'd1;
  localparam logic [2:0] OP_SIGNED_XCHG   = 3'd2;
  localparam logic [2:0] OP_UNSIGNED_LOAD = 3'd3;
  localparam logic [2:0] OP_UNSIGNED_XCHG = 3'd4;

  localparam logic [XlenW-1:0] IP_VALID_BIT = 32'h0000_0002;
  localparam logic [XlenW-1:0] WORD_STEP    = 32'h0000_0004;

  typedef struct packed {
    logic               command;
    logic [XlenW-1:0]   access_address;
    logic [RegNumW-1:0] reg_number;
    logic [XlenW-1:0]   reg_value;
    logic [XlenW-1:0]   reg_value_next;
    logic [1:0]         access_size;
    logic [2:0]         op_kind;
    logic               is_write;
    logic               supervisor;
    logic [XlenW-1:0]   exec_ip;
    logic [XlenW-1:0]   branch_target;
    logic               delayed_valid;
  } dfsr_in_t;

  typedef struct packed {
    logic [15:0]      trans0;
    logic [15:0]      trans1;
    logic [XlenW-1:0] data0;
    logic [XlenW-1:0] data1;
    logic [XlenW-1:0] addr0;
    logic [XlenW-1:0] addr1;
    logic [XlenW-1:0] scoreboard;
    logic [XlenW-1:0] exec_shadow;
    logic [XlenW-1:0] next_shadow;
    logic [XlenW-1:0] fetch_shadow;
  } dfsr_out_t;

  typedef struct packed {
    logic               endian;
    logic               mode;
    logic               dbl;
    logic               lock;
    logic [RegNumW-1:0] reg_num;
    logic               sgn;
    logic [3:0]         byte_en;
    logic               write;
    logic               valid;
  } dfsr_trans_t;

  typedef struct packed {
    dfsr_trans_t      trans0;
    dfsr_trans_t      trans1;
    logic [XlenW-1:0] data0;
    logic [XlenW-1:0] data1;
    logic [XlenW-1:0] addr0;
    logic [XlenW-1:0] addr1;
    logic [XlenW-1:0] busy;
    logic [XlenW-1:0] exec_sh;
    logic [XlenW-1:0] next_sh;
    logic [XlenW-1:0] fetch_sh;
  } dfsr_state_t;

  typedef struct packed {
    logic shadow_frozen;
    logic endian_mode;
  } dfsr_cfg_t;

endpackage

>>> hdl/dfsr_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
`timescale 1ns / 1ps

interface dfsr_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/data_fault_shadow_registers.sv
// Top level of the data fault shadow registers block.
// The input channel in_i carries one transaction per item: either a faulted
// data access record or an instruction pointer shadow load. The result channel
// out_o carries, for every input transaction, one snapshot of the transaction,
// data, address, scoreboard and shadow registers after that item.
// An accepted item sits in an input register and is applied to the register set,
// which doubles as the result register, once that holds no result still waiting.
// One item per cycle is sustained while the receiver does not stall.
// While a result waits on a stalled receiver, one more item is taken into the
// input register; the input channel stalls only when both are full.
// The configuration port writes the frozen and endian bits via cfg_we_i, cfg_idx_i
// and cfg_wdata_i; the user must write it only while idle, the block does not check.
// Reset clears the register set, both configuration bits and both valid flags.
`timescale 1ns / 1ps

module data_fault_shadow_registers import dfsr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  dfsr_stream_if.sink   in_i,
  dfsr_stream_if.source out_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic          cfg_wdata_i
);

  logic        s1_valid;
  dfsr_in_t    s1_item;
  logic        advance;
  logic        out_valid_q;
  dfsr_state_t state_q;
  dfsr_state_t state_d;
  dfsr_cfg_t   cfg_q;

  assign advance = s1_valid && (!out_valid_q || out_o.ready);

  dfsr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  dfsr_update u_update (
    .item_i  (s1_item),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHADOW_FROZEN: cfg_q.shadow_frozen <= cfg_wdata_i;
        CFG_ENDIAN_MODE:   cfg_q.endian_mode   <= cfg_wdata_i;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
      state_q     <= state_d;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.data.trans0       = state_q.trans0;
  assign out_o.data.trans1       = state_q.trans1;
  assign out_o.data.data0        = state_q.data0;
  assign out_o.data.data1        = state_q.data1;
  assign out_o.data.addr0        = state_q.addr0;
  assign out_o.data.addr1        = state_q.addr1;
  assign out_o.data.scoreboard   = state_q.busy;
  assign out_o.data.exec_shadow  = state_q.exec_sh;
  assign out_o.data.next_shadow  = state_q.next_sh;
  assign out_o.data.fetch_shadow = state_q.fetch_sh;

endmodule

>>> hdl/dfsr_in_stage.sv
// Input register stage that holds one accepted transaction until it is processed.
`timescale 1ns / 1ps

module dfsr_in_stage import dfsr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  dfsr_stream_if.sink   in_i,
  input  logic          advance_i,
  output logic          valid_o,
  output dfsr_in_t      item_o
);

  logic     valid_q;
  dfsr_in_t item_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_i.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hdl/dfsr_update.sv
// Next-state logic: applies one fault record or shadow load to the register set.
`timescale 1ns / 1ps

module dfsr_update import dfsr_pkg::*; (
  input  dfsr_in_t    item_i,
  input  dfsr_cfg_t   cfg_i,
  input  dfsr_state_t state_i,
  output dfsr_state_t state_o
);

  dfsr_trans_t        t;
  logic [XlenW-1:0]   addr_al;
  logic [XlenW-1:0]   next_ip;
  logic [7:0]         b;
  logic [15:0]        h;
  logic [RegNumW-1:0] rn_next;

  assign b       = item_i.reg_value[7:0];
  assign h       = item_i.reg_value[15:0];
  assign rn_next = item_i.reg_number + RegNumW'(1);
  assign addr_al = {item_i.access_address[XlenW-1:2], 2'b00};
  assign next_ip = item_i.delayed_valid ? (item_i.branch_target | IP_VALID_BIT)
                                        : ((item_i.exec_ip | IP_VALID_BIT) + WORD_STEP);

  always_comb begin
    t         = '0;
    t.valid   = 1'b1;
    t.write   = item_i.is_write;
    t.reg_num = item_i.reg_number;
    t.mode    = item_i.supervisor;
    t.endian  = cfg_i.endian_mode;
    t.lock    = (item_i.op_kind == OP_SIGNED_XCHG) || (item_i.op_kind == OP_UNSIGNED_XCHG);
    t.sgn     = (item_i.op_kind == OP_SIGNED_LOAD) || (item_i.op_kind == OP_SIGNED_XCHG);
    case (item_i.access_size)
      SIZE_BYTE: t.byte_en = 4'b1000 >> item_i.access_address[1:0];
      SIZE_HALF: t.byte_en = item_i.access_address[1] ? 4'b0011 : 4'b1100;
      default:   t.byte_en = 4'b1111;
    endcase
  end

  always_comb begin
    state_o = state_i;
    if (item_i.command == CMD_FAULT) begin
      if (item_i.op_kind != OP_STORE) begin
        state_o.busy[item_i.reg_number] = 1'b1;
        if (item_i.access_size == SIZE_DOUBLE && item_i.reg_number != LAST_REG) begin
          state_o.busy[rn_next] = 1'b1;
        end
      end
      if (!cfg_i.shadow_frozen) begin
        state_o.addr0  = addr_al;
        state_o.trans0 = t;
        case (item_i.access_size)
          SIZE_BYTE: state_o.data0 = {4{b}};
          SIZE_HALF: state_o.data0 = {2{h}};
          SIZE_WORD: state_o.data0 = item_i.reg_value;
          SIZE_DOUBLE: begin
            state_o.data0          = item_i.reg_value;
            state_o.data1          = item_i.reg_value_next;
            state_o.addr1          = addr_al + WORD_STEP;
            state_o.trans1         = t;
            state_o.trans1.reg_num = rn_next;
            state_o.trans0.dbl     = 1'b1;
          end
          default: state_o.data0 = item_i.reg_value;
        endcase
      end
    end else if (!cfg_i.shadow_frozen) begin
      state_o.exec_sh  = item_i.exec_ip | IP_VALID_BIT;
      state_o.next_sh  = next_ip;
      state_o.fetch_sh = next_ip + WORD_STEP;
      state_o.trans0   = '0;
      state_o.trans1   = '0;
      state_o.data0    = '0;
      state_o.data1    = '0;
      state_o.addr0    = '0;
      state_o.addr1    = '0;
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the data fault shadow registers block.
`timescale 1ns / 1ps

module tb_top;
  import dfsr_pkg::*;

  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam int unsigned PRINT_CAP = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = CFG_SHADOW_FROZEN;
  logic cfg_wdata = 1'b0;

  dfsr_stream_if #(.T(dfsr_in_t))  in_ch ();
  dfsr_stream_if #(.T(dfsr_out_t)) out_ch ();

  data_fault_shadow_registers i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  dfsr_in_t    access_q[$];
  dfsr_out_t   snapshot_q[$];
  dfsr_state_t model_regs;
  dfsr_cfg_t   model_cfg;
  bit          quiet;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned mismatch_cnt;
  int unsigned fault_cnt;
  int unsigned shadow_cnt;
  int unsigned result_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic dfsr_out_t advance_regs(input dfsr_in_t it);
    dfsr_trans_t t;
    dfsr_out_t   snap;
    logic [4:0]  rn_next;
    rn_next = it.reg_number + 5'd1;
    if (it.command == CMD_SHADOW) begin
      if (!model_cfg.shadow_frozen) begin
        model_regs.exec_sh = it.exec_ip | IP_VALID_BIT;
        model_regs.next_sh = it.delayed_valid ? (it.branch_target | IP_VALID_BIT)
                                              : model_regs.exec_sh + WORD_STEP;
        model_regs.fetch_sh = model_regs.next_sh + WORD_STEP;
        model_regs.trans0 = '0;
        model_regs.trans1 = '0;
        model_regs.data0 = '0;
        model_regs.data1 = '0;
        model_regs.addr0 = '0;
        model_regs.addr1 = '0;
      end
    end else begin
      if (it.op_kind != OP_STORE) begin
        model_regs.busy[it.reg_number] = 1'b1;
        if (it.access_size == SIZE_DOUBLE && it.reg_number != LAST_REG)
          model_regs.busy[rn_next] = 1'b1;
      end
      if (!model_cfg.shadow_frozen) begin
        t = '0;
        t.valid = 1'b1;
        t.write = it.is_write;
        t.reg_num = it.reg_number;
        t.mode = it.supervisor;
        t.endian = model_cfg.endian_mode;
        t.lock = (it.op_kind == OP_SIGNED_XCHG) || (it.op_kind == OP_UNSIGNED_XCHG);
        t.sgn = (it.op_kind == OP_SIGNED_LOAD) || (it.op_kind == OP_SIGNED_XCHG);
        model_regs.addr0 = {it.access_address[31:2], 2'b00};
        case (it.access_size)
          SIZE_BYTE: begin
            model_regs.data0 = {4{it.reg_value[7:0]}};
            t.byte_en = 4'b1000 >> it.access_address[1:0];
          end
          SIZE_HALF: begin
            model_regs.data0 = {2{it.reg_value[15:0]}};
            t.byte_en = it.access_address[1] ? 4'b0011 : 4'b1100;
          end
          SIZE_WORD: begin
            model_regs.data0 = it.reg_value;
            t.byte_en = 4'b1111;
          end
          default: begin
            t.byte_en = 4'b1111;
            model_regs.data0 = it.reg_value;
            model_regs.addr1 = model_regs.addr0 + WORD_STEP;
            model_regs.data1 = it.reg_value_next;
            model_regs.trans1 = t;
            model_regs.trans1.reg_num = rn_next;
            t.dbl = 1'b1;
          end
        endcase
        model_regs.trans0 = t;
      end
    end
    snap.trans0 = model_regs.trans0;
    snap.trans1 = model_regs.trans1;
    snap.data0 = model_regs.data0;
    snap.data1 = model_regs.data1;
    snap.addr0 = model_regs.addr0;
    snap.addr1 = model_regs.addr1;
    snap.scoreboard = model_regs.busy;
    snap.exec_shadow = model_regs.exec_sh;
    snap.next_shadow = model_regs.next_sh;
    snap.fetch_shadow = model_regs.fetch_sh;
    return snap;
  endfunction

  function automatic dfsr_in_t rand_access();
    dfsr_in_t it;
    it.command = ($urandom_range(0, 99) < 20) ? CMD_SHADOW : CMD_FAULT;
    it.access_address = $urandom;
    it.reg_number = 5'($urandom_range(0, 31));
    it.reg_value = $urandom;
    it.reg_value_next = $urandom;
    it.access_size = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 8)
      it.op_kind = 3'($urandom_range(OP_SIGNED_LOAD, OP_UNSIGNED_XCHG));
    else
      it.op_kind = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    it.is_write = 1'($urandom_range(0, 1));
    it.supervisor = 1'($urandom_range(0, 1));
    it.exec_ip = $urandom;
    it.branch_target = $urandom;
    it.delayed_valid = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic dfsr_in_t mk_fault(input logic [31:0] addr, input logic [4:0] rn,
                                        input logic [31:0] val, input logic [31:0] valn,
                                        input logic [1:0] size, input logic [2:0] op,
                                        input logic wr, input logic sup);
    dfsr_in_t it;
    it = rand_access();
    it.command = CMD_FAULT;
    it.access_address = addr;
    it.reg_number = rn;
    it.reg_value = val;
    it.reg_value_next = valn;
    it.access_size = size;
    it.op_kind = op;
    it.is_write = wr;
    it.supervisor = sup;
    return it;
  endfunction

  function automatic dfsr_in_t mk_shadow(input logic [31:0] xip, input logic [31:0] tip,
                                         input logic dv);
    dfsr_in_t it;
    it = rand_access();
    it.command = CMD_SHADOW;
    it.exec_ip = xip;
    it.branch_target = tip;
    it.delayed_valid = dv;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP)
      $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic check_snapshot(input dfsr_out_t got);
    dfsr_out_t want;
    result_cnt++;
    if (snapshot_q.size() == 0) begin
      report_mismatch("result with no pending transaction", got.scoreboard, '0);
    end else begin
      want = snapshot_q.pop_front();
      if (got.trans0 !== want.trans0)
        report_mismatch("trans0", 32'(got.trans0), 32'(want.trans0));
      if (got.trans1 !== want.trans1)
        report_mismatch("trans1", 32'(got.trans1), 32'(want.trans1));
      if (got.data0 !== want.data0) report_mismatch("data0", got.data0, want.data0);
      if (got.data1 !== want.data1) report_mismatch("data1", got.data1, want.data1);
      if (got.addr0 !== want.addr0) report_mismatch("addr0", got.addr0, want.addr0);
      if (got.addr1 !== want.addr1) report_mismatch("addr1", got.addr1, want.addr1);
      if (got.scoreboard !== want.scoreboard)
        report_mismatch("scoreboard", got.scoreboard, want.scoreboard);
      if (got.exec_shadow !== want.exec_shadow)
        report_mismatch("exec_shadow", got.exec_shadow, want.exec_shadow);
      if (got.next_shadow !== want.next_shadow)
        report_mismatch("next_shadow", got.next_shadow, want.next_shadow);
      if (got.fetch_shadow !== want.fetch_shadow)
        report_mismatch("fetch_shadow", got.fetch_shadow, want.fetch_shadow);
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        snapshot_q.push_back(advance_regs(in_ch.data));
        if (in_ch.data.command == CMD_SHADOW) shadow_cnt++;
        else fault_cnt++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (access_q.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= access_q.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_snapshot(out_ch.data);
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_stall <= pick_gap();
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (access_q.size() != 0 || in_ch.valid || snapshot_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SHADOW_FROZEN) model_cfg.shadow_frozen = val;
    else model_cfg.endian_mode = val;
  endtask

  task automatic run_batch(input int unsigned n, input bit burst);
    @(negedge clk);
    quiet = burst;
    repeat (n) access_q.push_back(rand_access());
    wait_idle();
  endtask

  initial begin
    model_regs = '0;
    model_cfg = '0;
    quiet = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_cfg(CFG_SHADOW_FROZEN, 1'b0);
    write_cfg(CFG_ENDIAN_MODE, 1'b0);
    @(negedge clk);
    access_q.push_back(mk_fault(32'h0000_1000, 5'd0, 32'h0000_00a5, 32'h0, SIZE_BYTE,
                                OP_SIGNED_LOAD, 1'b0, 1'b0));
    access_q.push_back(mk_fault(32'h0000_1001, 5'd1, 32'h1234_5678, 32'h0, SIZE_BYTE,
                                OP_STORE, 1'b1, 1'b1));
    access_q.push_back(mk_fault(32'h0000_1002, 5'd2, 32'hffff_ff80, 32'h0, SIZE_BYTE,
                                OP_SIGNED_XCHG, 1'b1, 1'b0));
    access_q.push_back(mk_fault(32'h0000_1003, 5'd3, 32'h0000_007f, 32'h0, SIZE_BYTE,
                                OP_UNSIGNED_LOAD, 1'b0, 1'b1));
    access_q.push_back(mk_fault(32'h8000_0000, 5'd4, 32'hdead_beef, 32'h0, SIZE_HALF,
                                OP_UNSIGNED_XCHG, 1'b1, 1'b0));
    access_q.push_back(mk_fault(32'h8000_0002, 5'd5, 32'h0000_8001, 32'h0, SIZE_HALF,
                                OP_UNDEF_LO, 1'b0, 1'b0));
    access_q.push_back(mk_fault(32'hffff_ffff, 5'd31, 32'hffff_ffff, 32'hffff_ffff,
                                SIZE_WORD, OP_UNDEF_HI, 1'b1, 1'b1));
    access_q.push_back(mk_fault(32'hffff_fffc, 5'd31, 32'h0123_4567, 32'h89ab_cdef,
                                SIZE_DOUBLE, OP_SIGNED_LOAD, 1'b0, 1'b1));
    access_q.push_back(mk_fault(32'h0000_0000, 5'd0, 32'h0000_0000, 32'hffff_ffff,
                                SIZE_DOUBLE, OP_STORE, 1'b1, 1'b0));
    access_q.push_back(mk_fault(32'h0000_4006, 5'd15, 32'haaaa_5555, 32'h5555_aaaa,
                                SIZE_DOUBLE, OP_UNSIGNED_XCHG, 1'b1, 1'b1));
    access_q.push_back(mk_shadow(32'hffff_fffc, 32'h0000_0000, 1'b0));
    access_q.push_back(mk_fault(32'h0000_2008, 5'd9, 32'hcafe_f00d, 32'h0, SIZE_WORD,
                                OP_SIGNED_XCHG, 1'b0, 1'b0));
    access_q.push_back(mk_shadow(32'h0000_0000, 32'hffff_ffff, 1'b1));
    access_q.push_back(mk_fault(32'h0000_300d, 5'd20, 32'h0000_00ff, 32'h0, SIZE_BYTE,
                                OP_UNDEF_HI, 1'b0, 1'b1));
    wait_idle();

    run_batch(150, 1'b0);
    run_batch(150, 1'b0);

    write_cfg(CFG_ENDIAN_MODE, 1'b1);
    run_batch(250, 1'b0);
    run_batch(80, 1'b1);

    write_cfg(CFG_SHADOW_FROZEN, 1'b1);
    @(negedge clk);
    quiet = 1'b0;
    access_q.push_back(mk_fault(32'h0000_5001, 5'd30, 32'h1111_2222, 32'h3333_4444,
                                SIZE_DOUBLE, OP_SIGNED_LOAD, 1'b1, 1'b1));
    access_q.push_back(mk_fault(32'h0000_6002, 5'd7, 32'h5555_6666, 32'h0, SIZE_HALF,
                                OP_STORE, 1'b1, 1'b0));
    access_q.push_back(mk_shadow(32'h0000_7000, 32'h0000_9000, 1'b1));
    wait_idle();
    run_batch(200, 1'b0);

    write_cfg(CFG_ENDIAN_MODE, 1'b0);
    run_batch(150, 1'b0);

    write_cfg(CFG_SHADOW_FROZEN, 1'b0);
    run_batch(250, 1'b0);
    run_batch(70, 1'b1);

    while (snapshot_q.size() != 0) begin
      void'(snapshot_q.pop_front());
      report_mismatch("transaction with no result", '0, '0);
    end

    $display("Checked %0d snapshots from %0d fault records and %0d shadow loads,",
             result_cnt, fault_cnt, shadow_cnt);
    $display("covering all four settings of the frozen and endian bits.");
    if (mismatch_cnt == 0) begin
      $display("data_fault_shadow_registers verification clean");
    end else begin
      $display("data_fault_shadow_registers verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("data_fault_shadow_registers verification failed");
    $finish;
  end

endmodule
